// ===== rtl/aps_pkg.sv =====
package aps_pkg;

  localparam int TASK_W  = 8;
  localparam int BASE_W  = 8;
  localparam int WAIT_W  = 16;
  localparam int PRIO_W  = 25;
  localparam int BURST_W = 16;
  localparam int TIME_W  = 32;
  localparam int RATE_W  = 9;

  localparam logic OP_TICK    = 1'b0;
  localparam logic OP_ARRIVAL = 1'b1;

  // one ready-table entry as held in the slot memory
  typedef struct packed {
    logic [TASK_W-1:0]  task_id;
    logic [BASE_W-1:0]  base;
    logic [WAIT_W-1:0]  wait_cnt;
    logic [PRIO_W-1:0]  prio;
    logic [BURST_W-1:0] remaining;
    logic [BURST_W-1:0] burst;
    logic [TIME_W-1:0]  arrival;
  } slot_rec_t;

endpackage

// ===== rtl/aps_slot_mem.sv =====
module aps_slot_mem
  import aps_pkg::*;
#(
  parameter int SLOTS = 16,
  parameter int IW    = 4
) (
  input  logic            clk,
  input  logic            we,
  input  logic [IW-1:0]   waddr,
  input  slot_rec_t       wdata,
  input  logic [IW-1:0]   raddr,
  output slot_rec_t       rdata
);

  slot_rec_t mem [SLOTS];
  slot_rec_t rdata_r;

  // write one entry, read one entry with registered data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/aps_age_unit.sv =====
module aps_age_unit
  import aps_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  logic [WAIT_W-1:0] wait_cnt,
  input  logic [RATE_W-1:0] rate,
  input  logic [BASE_W-1:0] base,
  output logic [PRIO_W-1:0] prio
);

  logic [PRIO_W-1:0] prod_r;
  logic [BASE_W-1:0] base_r;

  // register the aging product, then add the scaled base priority
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= PRIO_W'(rate) * PRIO_W'(wait_cnt);
      base_r <= base;
    end
  end

  assign prio = {(PRIO_W-BASE_W-8)'(0), base_r, 8'd0} + prod_r;

endmodule

// ===== rtl/aging_priority_task_scheduler_unit.sv =====
// Preemptive priority scheduler with aging over a table of SLOTS entries. One
// request at a time: an arrival scans the valid bits for the lowest free slot
// (one slot a cycle) and then reads the running task, if there is one. A tick
// walks the whole table through the slot memory (one read and one write port)
// and the shared aging multiplier, reading each slot and aging and writing back
// each occupied one but the running task's, then selects and executes. The
// result goes to the output register, which holds it until taken while the
// next request runs.
module aging_priority_task_scheduler_unit
  import aps_pkg::*;
#(
  parameter int SLOTS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [RATE_W-1:0]  cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_operation,
  input  logic [TASK_W-1:0]  in_task_id,
  input  logic [BASE_W-1:0]  in_start_prio,
  input  logic [BURST_W-1:0] in_burst_length,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_running_valid,
  output logic [TASK_W-1:0]  out_running_id,
  output logic               out_context_switch,
  output logic               out_finished_valid,
  output logic [TASK_W-1:0]  out_finished_id,
  output logic [TIME_W-1:0]  out_finished_turnaround,
  output logic [TIME_W-1:0]  out_finished_waiting,
  output logic               out_arrival_rejected
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_AFIND = 11'b00000000010,
    S_AWR   = 11'b00000000100,
    S_SRD   = 11'b00000001000,
    S_SMUL  = 11'b00000010000,
    S_SUPD  = 11'b00000100000,
    S_SEL   = 11'b00001000000,
    S_RRD   = 11'b00010000000,
    S_EXE   = 11'b00100000000,
    S_FIN   = 11'b01000000000,
    S_DONE  = 11'b10000000000
  } state_t;

  state_t             state_r;
  logic               op_r;
  logic [TASK_W-1:0]  req_task_r;
  logic [BASE_W-1:0]  req_base_r;
  logic [BURST_W-1:0] req_burst_r;
  logic [IW-1:0]      idx_r;
  logic [RATE_W-1:0]  rate_r;
  logic [TIME_W-1:0]  tick_r;
  logic [SLOTS-1:0]   valid_r;
  logic               run_valid_r;
  logic [IW-1:0]      run_slot_r;
  logic               have_r;
  logic [IW-1:0]      best_slot_r;
  logic [PRIO_W-1:0]  best_prio_r;
  logic [TIME_W-1:0]  best_arr_r;
  logic [PRIO_W-1:0]  run_prio_r;
  logic               is_run_r;
  logic [WAIT_W-1:0]  wait_new_r;
  logic [TIME_W-1:0]  turn_r;

  logic               res_run_valid_r;
  logic [TASK_W-1:0]  res_run_id_r;
  logic               res_cs_r;
  logic               res_fin_valid_r;
  logic [TASK_W-1:0]  res_fin_id_r;
  logic [TIME_W-1:0]  res_wait_r;
  logic               res_rej_r;

  logic               out_valid_r;
  logic               out_run_valid_r;
  logic [TASK_W-1:0]  out_run_id_r;
  logic               out_cs_r;
  logic               out_fin_valid_r;
  logic [TASK_W-1:0]  out_fin_id_r;
  logic [TIME_W-1:0]  out_turn_r;
  logic [TIME_W-1:0]  out_wait_r;
  logic               out_rej_r;

  slot_rec_t          rec;
  slot_rec_t          mem_wdata;
  logic               mem_we;
  logic [IW-1:0]      mem_waddr;
  logic [IW-1:0]      mem_raddr;
  logic [PRIO_W-1:0]  age_prio;
  logic [WAIT_W-1:0]  wait_inc;
  logic [PRIO_W-1:0]  cand_prio;
  logic               cand_beats;
  logic [BURST_W-1:0] rem_dec;
  logic [BURST_W-1:0] burst_fix;

  aps_slot_mem #(.SLOTS(SLOTS), .IW(IW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (rec)
  );

  aps_age_unit u_age (
    .clk      (clk),
    .en       (state_r == S_SMUL),
    .wait_cnt (wait_inc),
    .rate     (rate_r),
    .base     (rec.base),
    .prio     (age_prio)
  );

  // saturating wait increment (held for the running task), candidate compare, countdown
  assign wait_inc   = (rec.wait_cnt == '1 || is_run_r) ? rec.wait_cnt : rec.wait_cnt + 1'b1;
  assign cand_prio  = is_run_r ? rec.prio : age_prio;
  assign cand_beats = !have_r || (cand_prio > best_prio_r) ||
                      ((cand_prio == best_prio_r) && (rec.arrival < best_arr_r));
  assign rem_dec    = (rec.remaining != '0) ? rec.remaining - 1'b1 : '0;
  assign burst_fix  = (req_burst_r == '0) ? BURST_W'(1) : req_burst_r;
  // keep the running slot on the read port through execution and retirement
  assign mem_raddr  = (state_r == S_RRD || state_r == S_EXE) ? run_slot_r : idx_r;

  // steer the single write port
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx_r;
    mem_wdata = rec;
    unique case (state_r)
      S_AWR: begin
        mem_we              = 1'b1;
        mem_wdata.task_id   = req_task_r;
        mem_wdata.base      = req_base_r;
        mem_wdata.wait_cnt  = '0;
        mem_wdata.prio      = {(PRIO_W-BASE_W-8)'(0), req_base_r, 8'd0};
        mem_wdata.remaining = burst_fix;
        mem_wdata.burst     = burst_fix;
        mem_wdata.arrival   = tick_r;
      end
      S_SUPD: begin
        mem_we             = !is_run_r;
        mem_wdata.wait_cnt = wait_new_r;
        mem_wdata.prio     = age_prio;
      end
      S_EXE: begin
        mem_we              = (op_r == OP_TICK);
        mem_waddr           = run_slot_r;
        mem_wdata.remaining = rem_dec;
      end
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rate_r      <= '0;
      tick_r      <= '0;
      valid_r     <= '0;
      run_valid_r <= 1'b0;
      run_slot_r  <= '0;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
      have_r      <= 1'b0;
    end else begin
      if (cfg_we) begin
        rate_r <= cfg_wdata;
      end
      if (out_valid_r && out_ready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            op_r            <= in_operation;
            req_task_r      <= in_task_id;
            req_base_r      <= in_start_prio;
            req_burst_r     <= in_burst_length;
            idx_r           <= '0;
            have_r          <= 1'b0;
            res_run_valid_r <= 1'b0;
            res_run_id_r    <= '0;
            res_cs_r        <= 1'b0;
            res_fin_valid_r <= 1'b0;
            res_fin_id_r    <= '0;
            turn_r          <= '0;
            res_wait_r      <= '0;
            res_rej_r       <= 1'b0;
            state_r <= (in_operation == OP_ARRIVAL) ? S_AFIND : S_SRD;
          end
        end
        // find the lowest free slot
        S_AFIND: begin
          if (!valid_r[idx_r]) begin
            state_r <= S_AWR;
          end else if (idx_r == LAST) begin
            res_rej_r <= 1'b1;
            state_r   <= run_valid_r ? S_RRD : S_DONE;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        S_AWR: begin
          valid_r[idx_r] <= 1'b1;
          state_r        <= run_valid_r ? S_RRD : S_DONE;
        end
        // walk the table: read, age, write back and compare
        S_SRD: begin
          is_run_r <= run_valid_r && (idx_r == run_slot_r);
          if (valid_r[idx_r]) begin
            state_r <= S_SMUL;
          end else if (idx_r == LAST) begin
            state_r <= S_SEL;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        S_SMUL: begin
          wait_new_r <= wait_inc;
          state_r    <= S_SUPD;
        end
        S_SUPD: begin
          if (is_run_r) begin
            run_prio_r <= cand_prio;
          end
          if (cand_beats) begin
            have_r      <= 1'b1;
            best_slot_r <= idx_r;
            best_prio_r <= cand_prio;
            best_arr_r  <= rec.arrival;
          end
          if (idx_r == LAST) begin
            state_r <= S_SEL;
          end else begin
            idx_r   <= idx_r + 1'b1;
            state_r <= S_SRD;
          end
        end
        // pick the task to run, preempt only on strictly higher priority
        S_SEL: begin
          if (have_r && (!run_valid_r ||
              (best_slot_r != run_slot_r && best_prio_r > run_prio_r))) begin
            run_slot_r  <= best_slot_r;
            run_valid_r <= 1'b1;
            res_cs_r    <= 1'b1;
          end
          if (run_valid_r || have_r) begin
            state_r <= S_RRD;
          end else begin
            tick_r  <= tick_r + 1'b1;
            state_r <= S_DONE;
          end
        end
        S_RRD: begin
          state_r <= S_EXE;
        end
        // on a tick, run the task for one tick and retire it on its last; on an arrival, only report it
        S_EXE: begin
          res_run_valid_r <= 1'b1;
          res_run_id_r    <= rec.task_id;
          if (op_r == OP_ARRIVAL) begin
            state_r <= S_DONE;
          end else begin
            tick_r <= tick_r + 1'b1;
            if (rem_dec == '0) begin
              res_fin_valid_r     <= 1'b1;
              res_fin_id_r        <= rec.task_id;
              turn_r              <= tick_r + 1'b1 - rec.arrival;
              valid_r[run_slot_r] <= 1'b0;
              run_valid_r         <= 1'b0;
              state_r             <= S_FIN;
            end else begin
              state_r <= S_DONE;
            end
          end
        end
        S_FIN: begin
          res_wait_r <= (turn_r >= TIME_W'(rec.burst)) ? turn_r - TIME_W'(rec.burst) : '0;
          state_r    <= S_DONE;
        end
        // hand the result to the output register
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r     <= 1'b1;
            out_run_valid_r <= res_run_valid_r;
            out_run_id_r    <= res_run_id_r;
            out_cs_r        <= res_cs_r;
            out_fin_valid_r <= res_fin_valid_r;
            out_fin_id_r    <= res_fin_id_r;
            out_turn_r      <= turn_r;
            out_wait_r      <= res_wait_r;
            out_rej_r       <= res_rej_r;
            state_r         <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready                = (state_r == S_IDLE);
  assign out_valid               = out_valid_r;
  assign out_running_valid       = out_run_valid_r;
  assign out_running_id          = out_run_id_r;
  assign out_context_switch      = out_cs_r;
  assign out_finished_valid      = out_fin_valid_r;
  assign out_finished_id         = out_fin_id_r;
  assign out_finished_turnaround = out_turn_r;
  assign out_finished_waiting    = out_wait_r;
  assign out_arrival_rejected    = out_rej_r;

endmodule

// ===== rtl/aps_checker.sv =====
module aps_checker
  import aps_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic              out_running_valid,
  input logic [TASK_W-1:0] out_running_id,
  input logic              out_context_switch,
  input logic              out_finished_valid,
  input logic [TASK_W-1:0] out_finished_id,
  input logic [TIME_W-1:0] out_finished_turnaround,
  input logic [TIME_W-1:0] out_finished_waiting,
  input logic              out_arrival_rejected
);

  // hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_finished_turnaround))
    else $error("stalled result changed");

  // a retiring task is the one that ran
  a_fin_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_finished_valid |-> out_running_valid &&
    out_finished_id == out_running_id)
    else $error("retired task did not run");

  // waiting stays below turnaround
  a_wait: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_finished_valid |-> out_finished_waiting < out_finished_turnaround)
    else $error("waiting not below turnaround");

  // a rejected arrival carries no tick results
  a_rej: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_arrival_rejected |-> !out_context_switch && !out_finished_valid)
    else $error("rejected arrival with tick results");

  // a switch names a running task
  a_cs: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_context_switch |-> out_running_valid)
    else $error("switch without running task");

endmodule

bind aging_priority_task_scheduler_unit aps_checker u_aps_checker (
  .clk                     (clk),
  .rst_n                   (rst_n),
  .out_valid               (out_valid),
  .out_ready               (out_ready),
  .out_running_valid       (out_running_valid),
  .out_running_id          (out_running_id),
  .out_context_switch      (out_context_switch),
  .out_finished_valid      (out_finished_valid),
  .out_finished_id         (out_finished_id),
  .out_finished_turnaround (out_finished_turnaround),
  .out_finished_waiting    (out_finished_waiting),
  .out_arrival_rejected    (out_arrival_rejected)
);
